// File: rtl/qrf_pkg.sv
// qrf_pkg: widths, limits and shared types of the qr finder row scanner
// no dependencies; used by the stream interfaces and by qr_finder_row_scan
package qrf_pkg;

    // image limits
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_ROWS  = 4096;

    // field widths fixed by the stream formats
    localparam int PIX_W      = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 12;
    localparam int WIDTH_OUT_W = 13;

    // internal widths derived from the limits
    localparam int COL_W = $clog2(MAX_WIDTH + 1);   // column counter, holds MAX_WIDTH
    localparam int POS_W = $clog2(MAX_WIDTH);       // clamped pixel column
    localparam int ROW_W = $clog2(MAX_ROWS);        // row counter
    localparam int LEN_W = COL_W;                   // one run length, up to MAX_WIDTH
    localparam int SUM_W = LEN_W + 3;               // sum of five runs
    localparam int PROD_W = SUM_W + 6;              // scaled sums for the ratio test

    localparam int NUM_RUNS = 5;
    localparam int FILL_W   = 3;

    // proportion test constants for the 1:1:3:1:1 pattern
    localparam int RUN_SCALE  = 70;
    localparam int SIDE_LO    = 4;
    localparam int SIDE_HI    = 16;
    localparam int MID_LO     = 24;
    localparam int MID_HI     = 36;
    localparam int MIN_TOTAL  = 7;
    localparam int MID_RUN    = 2;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd127;

    typedef logic [NUM_RUNS-1:0][LEN_W-1:0] qrf_runs_t;

    // a closed dark run with a full window, waiting for the ratio test
    typedef struct packed {
        qrf_runs_t        runs;       // index 0 oldest, index 4 the closed run
        logic [COL_W-1:0] close_col;  // column just past the closed run
        logic [ROW_W-1:0] row;
    } qrf_cand_t;

endpackage

// File: rtl/qrf_stream_if.sv
// qrf_stream_if: valid/ready channels for pixels in and finder results out
// depends on qrf_pkg for field widths
interface qrf_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [qrf_pkg::PIX_W-1:0] pixel;
    logic                      end_of_row;
    logic                      end_of_frame;

    modport source (output valid, pixel, end_of_row, end_of_frame, input ready);
    modport sink   (input valid, pixel, end_of_row, end_of_frame, output ready);
endinterface

interface qrf_result_if;
    logic                            valid;
    logic                            ready;
    logic [qrf_pkg::ROW_OUT_W-1:0]   row_index;
    logic [qrf_pkg::COL_OUT_W-1:0]   center_col;
    logic [qrf_pkg::WIDTH_OUT_W-1:0] pattern_width;

    modport source (output valid, row_index, center_col, pattern_width, input ready);
    modport sink   (input valid, row_index, center_col, pattern_width, output ready);
endinterface

// File: rtl/qr_finder_row_scan.sv
// qr_finder_row_scan: row scanner for 1:1:3:1:1 finder patterns in a gray pixel stream
// depends on qrf_pkg and on the interfaces in qrf_stream_if.sv

// Takes one pixel per clock in raster order, unless stalled, and reports a finder
// candidate (row, center column, pattern width) whenever a dark run closes and the
// last five runs read dark-light-dark-light-dark in about 1:1:3:1:1 proportion.
// The block sustains one pixel per cycle unless back pressure stalls it. A pixel
// passes through an input register, a run-tracking stage that holds the
// candidate window and a ratio-test stage that holds the result, and its result
// is valid on the output once it reaches the last of these. At most one result
// comes from a pixel. Back pressure on the result channel stalls the stages only
// as far as they are full.
module qr_finder_row_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [qrf_pkg::PIX_W-1:0] cfg_wdata,
    qrf_pixel_if.sink                 pixel_stream,
    qrf_result_if.source              finder_stream
);

    // shift a new run length into the window, oldest falls out
    function automatic qrf_pkg::qrf_runs_t shift_in(input qrf_pkg::qrf_runs_t win,
                                                    input logic [qrf_pkg::LEN_W-1:0] len);
        qrf_pkg::qrf_runs_t res;
        res = {len, win[qrf_pkg::NUM_RUNS-1:1]};
        return res;
    endfunction

    // configuration
    logic [qrf_pkg::PIX_W-1:0] threshold_reg;

    // input register stage
    logic                      s1_valid_reg;
    logic [qrf_pkg::PIX_W-1:0] s1_pixel_reg;
    logic                      s1_eor_reg;
    logic                      s1_eof_reg;

    // row tracking state
    logic [qrf_pkg::COL_W-1:0]  col_reg;
    logic [qrf_pkg::ROW_W-1:0]  row_reg;
    logic [qrf_pkg::POS_W-1:0]  run_start_reg;
    logic                       cur_dark_reg;
    qrf_pkg::qrf_runs_t         runs_reg;
    logic [qrf_pkg::FILL_W-1:0] filled_reg;

    // candidate stage
    logic               cand_valid_reg;
    qrf_pkg::qrf_cand_t cand_reg;

    // result stage
    logic                            out_valid_reg;
    logic [qrf_pkg::ROW_OUT_W-1:0]   out_row_reg;
    logic [qrf_pkg::COL_OUT_W-1:0]   out_col_reg;
    logic [qrf_pkg::WIDTH_OUT_W-1:0] out_width_reg;

    // stage flow control
    logic s3_load;
    logic s2_ready;
    logic s1_ready;
    logic s1_advance;

    assign s3_load    = !out_valid_reg || finder_stream.ready;
    assign s2_ready   = !cand_valid_reg || s3_load;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign s1_advance = s1_valid_reg && s2_ready;

    assign pixel_stream.ready = s1_ready;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= qrf_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pixel_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pixel_stream.valid)
        begin
            s1_pixel_reg <= pixel_stream.pixel;
            s1_eor_reg   <= pixel_stream.end_of_row || pixel_stream.end_of_frame;
            s1_eof_reg   <= pixel_stream.end_of_frame;
        end
    end

    // run tracking: up to two run closes per pixel
    logic                       dark;
    logic                       col_zero;
    logic [qrf_pkg::POS_W-1:0]  pos;
    logic [qrf_pkg::COL_W-1:0]  pos_plus;
    logic                       close_a;
    logic [qrf_pkg::LEN_W-1:0]  len_a;
    logic [qrf_pkg::LEN_W-1:0]  len_b;
    qrf_pkg::qrf_runs_t         win1;
    qrf_pkg::qrf_runs_t         win2;
    logic [qrf_pkg::FILL_W-1:0] filled1;
    logic [qrf_pkg::FILL_W-1:0] filled2;
    logic [qrf_pkg::POS_W-1:0]  rs1;
    logic                       hit_a;
    logic                       hit_b;
    logic                       cand_hit;
    qrf_pkg::qrf_cand_t         cand_next;
    logic [qrf_pkg::COL_W-1:0]  col_next;
    logic [qrf_pkg::ROW_W-1:0]  row_next;
    logic [qrf_pkg::POS_W-1:0]  run_start_next;
    qrf_pkg::qrf_runs_t         runs_next;
    logic [qrf_pkg::FILL_W-1:0] filled_next;

    always_comb
    begin
        dark     = s1_pixel_reg <= threshold_reg;
        col_zero = col_reg == '0;
        if (col_reg >= qrf_pkg::COL_W'(qrf_pkg::MAX_WIDTH))
        begin
            pos = qrf_pkg::POS_W'(qrf_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            pos = col_reg[qrf_pkg::POS_W-1:0];
        end
        pos_plus = qrf_pkg::COL_W'(pos) + qrf_pkg::COL_W'(1);

        // close on a change of color
        close_a = !col_zero && (dark != cur_dark_reg);
        len_a   = qrf_pkg::LEN_W'(pos) - qrf_pkg::LEN_W'(run_start_reg);
        if (close_a)
        begin
            win1    = shift_in(runs_reg, len_a);
            filled1 = (filled_reg == qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS)) ? filled_reg
                                                                         : filled_reg + 1'b1;
            rs1     = pos;
        end
        else
        begin
            win1    = runs_reg;
            filled1 = col_zero ? '0 : filled_reg;
            rs1     = col_zero ? '0 : run_start_reg;
        end
        hit_a = close_a && cur_dark_reg && (filled1 == qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS));

        // close at the end of the row, the open run now has the pixel's color
        len_b   = pos_plus - qrf_pkg::LEN_W'(rs1);
        win2    = shift_in(win1, len_b);
        filled2 = (filled1 == qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS)) ? filled1 : filled1 + 1'b1;
        hit_b   = s1_eor_reg && dark && (filled2 == qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS));

        // the two closes are of opposite colors, so only one can hit
        cand_hit      = hit_a || hit_b;
        cand_next.row = row_reg;
        if (hit_b)
        begin
            cand_next.runs      = win2;
            cand_next.close_col = pos_plus;
        end
        else
        begin
            cand_next.runs      = win1;
            cand_next.close_col = qrf_pkg::COL_W'(pos);
        end

        // next row state
        if (s1_eor_reg)
        begin
            col_next       = '0;
            run_start_next = '0;
            filled_next    = '0;
            runs_next      = win2;
            if (s1_eof_reg)
            begin
                row_next = '0;
            end
            else if (row_reg < qrf_pkg::ROW_W'(qrf_pkg::MAX_ROWS - 1))
            begin
                row_next = row_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg;
            end
        end
        else
        begin
            col_next       = (col_reg < qrf_pkg::COL_W'(qrf_pkg::MAX_WIDTH)) ? col_reg + 1'b1
                                                                            : col_reg;
            run_start_next = rs1;
            filled_next    = filled1;
            runs_next      = win1;
            row_next       = row_reg;
        end
    end

    // row state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            run_start_reg <= '0;
            cur_dark_reg  <= 1'b0;
            runs_reg      <= '0;
            filled_reg    <= '0;
        end
        else if (s1_advance)
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            run_start_reg <= run_start_next;
            cur_dark_reg  <= dark;
            runs_reg      <= runs_next;
            filled_reg    <= filled_next;
        end
    end

    // candidate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            cand_valid_reg <= s1_valid_reg && cand_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && cand_hit)
        begin
            cand_reg <= cand_next;
        end
    end

    // ratio test on the candidate window
    logic [qrf_pkg::SUM_W-1:0]  total;
    logic [qrf_pkg::PROD_W-1:0] scaled;
    logic [qrf_pkg::PROD_W-1:0] bound_lo;
    logic [qrf_pkg::PROD_W-1:0] bound_hi;
    logic                       ratio_ok;
    logic [qrf_pkg::COL_W-1:0]  center;

    always_comb
    begin
        total = '0;
        for (int i = 0; i < qrf_pkg::NUM_RUNS; i++)
        begin
            total = total + qrf_pkg::SUM_W'(cand_reg.runs[i]);
        end
        ratio_ok = total >= qrf_pkg::SUM_W'(qrf_pkg::MIN_TOTAL);
        scaled   = '0;
        bound_lo = '0;
        bound_hi = '0;
        for (int i = 0; i < qrf_pkg::NUM_RUNS; i++)
        begin
            scaled = qrf_pkg::PROD_W'(cand_reg.runs[i]) * qrf_pkg::PROD_W'(qrf_pkg::RUN_SCALE);
            if (i == qrf_pkg::MID_RUN)
            begin
                bound_lo = qrf_pkg::PROD_W'(total) * qrf_pkg::PROD_W'(qrf_pkg::MID_LO);
                bound_hi = qrf_pkg::PROD_W'(total) * qrf_pkg::PROD_W'(qrf_pkg::MID_HI);
            end
            else
            begin
                bound_lo = qrf_pkg::PROD_W'(total) * qrf_pkg::PROD_W'(qrf_pkg::SIDE_LO);
                bound_hi = qrf_pkg::PROD_W'(total) * qrf_pkg::PROD_W'(qrf_pkg::SIDE_HI);
            end
            if (scaled < bound_lo || scaled > bound_hi)
            begin
                ratio_ok = 1'b0;
            end
        end
        center = cand_reg.close_col - cand_reg.runs[4] - cand_reg.runs[3]
                 - (cand_reg.runs[qrf_pkg::MID_RUN] >> 1);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_load)
        begin
            out_valid_reg <= cand_valid_reg && ratio_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && cand_valid_reg)
        begin
            out_row_reg   <= qrf_pkg::ROW_OUT_W'(cand_reg.row);
            out_col_reg   <= qrf_pkg::COL_OUT_W'(center);
            out_width_reg <= qrf_pkg::WIDTH_OUT_W'(total);
        end
    end

    assign finder_stream.valid         = out_valid_reg;
    assign finder_stream.row_index     = out_row_reg;
    assign finder_stream.center_col    = out_col_reg;
    assign finder_stream.pattern_width = out_width_reg;

    // run window never counts past five
    assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS))
        else $error("run fill count beyond five");

    // the open run never starts past the current column
    assert property (@(posedge clk) disable iff (!rst_n)
        qrf_pkg::COL_W'(run_start_reg) <= col_reg)
        else $error("run start past column count");

    // a row end returns the column counter to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_eor_reg |=> col_reg == '0)
        else $error("column count not cleared at end of row");

    // a candidate only comes from a full window
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && cand_hit |-> filled2 == qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS)
                                   || filled1 == qrf_pkg::FILL_W'(qrf_pkg::NUM_RUNS))
        else $error("candidate raised on a partial window");

endmodule

// File: tb/qr_finder_row_scan_tb.sv
// qr_finder_row_scan_tb: self-checking bench for the 1:1:3:1:1 finder row scanner
// streams pixel rows through the dut, predicts every candidate and checks each result transfer
// depends on qrf_pkg, the stream interfaces in qrf_stream_if.sv and qr_finder_row_scan
module qr_finder_row_scan_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FINDER_MODULES [5] = '{1, 1, 3, 1, 1};

    typedef struct packed {
        logic [qrf_pkg::ROW_OUT_W-1:0]   row;
        logic [qrf_pkg::COL_OUT_W-1:0]   col;
        logic [qrf_pkg::WIDTH_OUT_W-1:0] width;
    } finder_hit_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [qrf_pkg::PIX_W-1:0] cfg_wdata;

    qrf_pixel_if  pix_if ();
    qrf_result_if hit_if ();

    // scanner state as the bench sees it
    logic [qrf_pkg::PIX_W-1:0] dark_level = qrf_pkg::THRESHOLD_RESET;
    logic [12:0]               col_cnt    = '0;
    logic [11:0]               row_cnt    = '0;
    logic [12:0]               run_begin  = '0;
    bit                        run_dark   = 1'b0;
    logic [12:0]               run_len [5] = '{default: '0};
    int unsigned               runs_held  = 0;

    finder_hit_t pending_hits [$];
    int unsigned hits_predicted = 0;
    int unsigned pixels_sent    = 0;
    int unsigned mismatches     = 0;
    int unsigned cycles         = 0;
    bit          src_idle       = 1'b1;
    bit          sink_idle      = 1'b1;

    qr_finder_row_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pixel_stream  (pix_if),
        .finder_stream (hit_if)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // proportion test over the five held runs
    function automatic bit ratio_ok();
        int unsigned total;
        int unsigned scaled;
        int unsigned lo;
        int unsigned hi;
        total = 0;
        foreach (run_len[i]) total += run_len[i];
        if (total < qrf_pkg::MIN_TOTAL)
            return 1'b0;
        foreach (run_len[i])
        begin
            scaled = qrf_pkg::RUN_SCALE * run_len[i];
            lo = (i == qrf_pkg::MID_RUN) ? qrf_pkg::MID_LO * total : qrf_pkg::SIDE_LO * total;
            hi = (i == qrf_pkg::MID_RUN) ? qrf_pkg::MID_HI * total : qrf_pkg::SIDE_HI * total;
            if (scaled < lo || scaled > hi)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // close the open run at column stop (exclusive), queue a candidate if it qualifies
    function automatic int retire_run(input int unsigned stop, input bit was_dark,
                                      input bit may_report);
        int unsigned len;
        int unsigned total;
        int unsigned center;
        finder_hit_t hit;
        len = stop - run_begin;
        if (len > qrf_pkg::MAX_WIDTH)
            len = qrf_pkg::MAX_WIDTH;
        if (runs_held < 5)
        begin
            run_len[runs_held] = 13'(len);
            runs_held++;
        end
        else
        begin
            for (int i = 0; i < 4; i++) run_len[i] = run_len[i+1];
            run_len[4] = 13'(len);
        end
        run_begin = 13'(stop);
        if (!may_report || runs_held < 5 || !was_dark || !ratio_ok())
            return 0;
        total = run_len[0] + run_len[1] + run_len[2] + run_len[3] + run_len[4];
        center = stop - run_len[4] - run_len[3] - run_len[2] / 2;
        hit.row = row_cnt;
        hit.col = center[11:0];
        hit.width = total[12:0];
        pending_hits.push_back(hit);
        hits_predicted++;
        return 1;
    endfunction

    // advance the scanner state by one accepted pixel
    function automatic void track_pixel(input logic [7:0] value, input bit row_end,
                                        input bit frame_end);
        int unsigned pos;
        bit          is_dark;
        bit          ends_row;
        int          found;
        ends_row = row_end | frame_end;
        pos = (col_cnt < qrf_pkg::MAX_WIDTH) ? col_cnt : qrf_pkg::MAX_WIDTH - 1;
        is_dark = (value <= dark_level);
        found = 0;
        if (col_cnt == 0)
        begin
            run_dark = is_dark;
            run_begin = '0;
            runs_held = 0;
        end
        else if (is_dark != run_dark)
        begin
            found += retire_run(pos, run_dark, 1'b1);
            run_dark = is_dark;
        end
        if (ends_row)
        begin
            found += retire_run(pos + 1, run_dark, found == 0);
            col_cnt = '0;
            run_begin = '0;
            runs_held = 0;
            if (frame_end)
                row_cnt = '0;
            else if (row_cnt < qrf_pkg::MAX_ROWS - 1)
                row_cnt++;
        end
        else if (col_cnt < qrf_pkg::MAX_WIDTH)
        begin
            col_cnt++;
        end
    endfunction

    // gray value on the requested side of the threshold, often right at the boundary
    function automatic logic [7:0] shade(input bit dark);
        if (dark)
            return ($urandom_range(0, 3) == 0) ? dark_level : 8'($urandom_range(0, dark_level));
        if (dark_level == 8'd255)
            return 8'd255;
        return ($urandom_range(0, 3) == 0) ? dark_level + 8'd1
                                           : 8'($urandom_range(dark_level + 1, 255));
    endfunction

    // one pixel transfer, with an optional gap before it
    task automatic send_pixel(input logic [7:0] value, input bit row_end, input bit frame_end);
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        pix_if.end_of_row <= row_end;
        pix_if.end_of_frame <= frame_end;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        track_pixel(value, row_end, frame_end);
        pixels_sent++;
    endtask

    // explicit gray values, row ends on the last one
    task automatic send_pixels(input logic [7:0] vals [$]);
        foreach (vals[i]) send_pixel(vals[i], i == vals.size() - 1, 1'b0);
    endtask

    // alternating runs of the given lengths; a frame end may come without a row end
    task automatic send_row(input bit first_dark, input int unsigned lens [$],
                            input bit frame_end);
        bit dark;
        bit last;
        dark = first_dark;
        foreach (lens[i])
        begin
            for (int unsigned k = 0; k < lens[i]; k++)
            begin
                last = (i == lens.size() - 1) && (k == lens[i] - 1);
                send_pixel(shade(dark), last && (!frame_end || $urandom_range(0, 1) == 1),
                           last && frame_end);
            end
            dark = !dark;
        end
    endtask

    // leading runs, a jittered finder pattern and an optional tail
    task automatic send_finder_row(input int unsigned unit_px, input int unsigned jitter,
                                   input bit frame_end);
        int unsigned lens [$];
        int unsigned n_lead;
        int unsigned n_tail;
        int          len;
        n_lead = $urandom_range(0, 3);
        for (int i = 0; i < n_lead; i++) lens.push_back($urandom_range(1, 8));
        foreach (FINDER_MODULES[i])
        begin
            len = FINDER_MODULES[i] * int'(unit_px) + int'($urandom_range(0, 2 * jitter))
                  - int'(jitter);
            lens.push_back(len < 1 ? 1 : len);
        end
        n_tail = $urandom_range(0, 3);
        for (int i = 0; i < n_tail; i++)
            lens.push_back((i == 0 && $urandom_range(0, 1) == 1) ? 1 : $urandom_range(1, 6));
        send_row(n_lead % 2 == 0, lens, frame_end);
    endtask

    // fully random gray values
    task automatic send_noise_row(input bit frame_end);
        int unsigned n;
        n = $urandom_range(1, 40);
        for (int unsigned k = 0; k < n; k++)
            send_pixel(8'($urandom_range(0, 255)), k == n - 1, (k == n - 1) && frame_end);
    endtask

    // wait until every candidate is out and the pipeline is empty
    task automatic settle();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dark_level = value;
    endtask

    // threshold boundaries at reset value and at both extremes, two closes on one pixel
    task automatic test_threshold_edges();
        send_pixels('{127, 128, 127, 127, 127, 128, 127});
        send_pixels('{128, 127, 128, 127, 127, 127, 128, 127, 128});
        write_threshold(8'd0);
        send_pixels('{0, 1, 0, 0, 0, 255, 0});
        write_threshold(8'd255);
        send_pixels('{255, 0, 255, 128, 255});
    endtask

    // proportion limits: too narrow, flat, uneven, in range, on both side bounds, past one, on the upper middle bound
    task automatic test_ratio_limits();
        write_threshold(8'd127);
        send_row(1'b1, '{1, 1, 1, 1, 1}, 1'b0);
        send_row(1'b1, '{4, 4, 4, 4, 4}, 1'b0);
        send_row(1'b1, '{1, 2, 3, 1, 1}, 1'b0);
        send_row(1'b1, '{2, 2, 6, 2, 2}, 1'b0);
        send_row(1'b1, '{8, 5, 12, 5, 5}, 1'b0);
        send_row(1'b1, '{9, 5, 11, 5, 5}, 1'b0);
        send_row(1'b1, '{2, 7, 12, 7, 7}, 1'b0);
        send_row(1'b1, '{4, 4, 18, 4, 5}, 1'b0);
    endtask

    // frame end brings the row counter back to zero
    task automatic test_frame_end();
        send_row(1'b1, '{1, 1, 3, 1, 1}, 1'b0);
        send_row(1'b1, '{2, 2, 6, 2, 2}, 1'b1);
        send_row(1'b1, '{1, 1, 3, 1, 1}, 1'b0);
    endtask

    // mostly finder rows with random content, some noise rows
    task automatic run_random_scan(input int unsigned n_pixels, input int unsigned n_hits);
        int unsigned pix0;
        int unsigned hit0;
        int unsigned m;
        pix0 = pixels_sent;
        hit0 = hits_predicted;
        while (pixels_sent - pix0 < n_pixels || hits_predicted - hit0 < n_hits)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_noise_row($urandom_range(0, 19) == 0);
            end
            else
            begin
                m = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
                send_finder_row(m, $urandom_range(0, m), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    task automatic test_random_scan();
        write_threshold(8'd127);
        run_random_scan(220, 8);
        write_threshold(8'($urandom_range(1, 254)));
        run_random_scan(220, 8);
        write_threshold(8'd0);
        run_random_scan(220, 8);
        write_threshold(8'($urandom_range(1, 254)));
        run_random_scan(220, 8);
        // last stretch runs at full rate on both sides
        src_idle = 1'b0;
        sink_idle = 1'b0;
        write_threshold(8'($urandom_range(1, 254)));
        run_random_scan(220, 8);
    endtask

    // stimulus and final verdict
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        pix_if.end_of_row = 1'b0;
        pix_if.end_of_frame = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_threshold_edges();
        test_ratio_limits();
        test_frame_end();
        test_random_scan();
        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side ready, stalled in random bursts
    initial
    begin : result_ready
        int unsigned stall_left;
        stall_left = 0;
        hit_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!sink_idle)
            begin
                hit_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                hit_if.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                hit_if.ready <= 1'b0;
            end
            else
            begin
                hit_if.ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest predicted candidate
    always @(posedge clk)
    begin : check_hits
        finder_hit_t want;
        if (rst_n && hit_if.valid && hit_if.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result: row_index %0d center_col %0d pattern_width %0d",
                       hit_if.row_index, hit_if.center_col, hit_if.pattern_width);
                mismatches++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit_if.row_index !== want.row)
                begin
                    $error("row_index expected %0d actual %0d", want.row, hit_if.row_index);
                    mismatches++;
                end
                if (hit_if.center_col !== want.col)
                begin
                    $error("center_col expected %0d actual %0d", want.col, hit_if.center_col);
                    mismatches++;
                end
                if (hit_if.pattern_width !== want.width)
                begin
                    $error("pattern_width expected %0d actual %0d", want.width,
                           hit_if.pattern_width);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/qrf_pkg.sv
rtl/qrf_stream_if.sv
rtl/qr_finder_row_scan.sv
tb/qr_finder_row_scan_tb.sv
